// ----- hw/rtl/jfke_pkg.sv -----
// Package for the JSON flat-object key extractor.
// Types, phase codes and status codes shared by all modules.
package jfke_pkg;
	localparam int MAX_KEY_BYTES = 8;
	localparam int OFFSET_BITS = 16;
	localparam int OUT_BITS = 16;
	localparam int KIDX_BITS = 4;
	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
	localparam logic [OUT_BITS-1:0] LEN_MAX = '1;
	localparam int QDEPTH = 4;
	localparam int QPTR_BITS = 2;

	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [3:0] {
		PH_OPEN, PH_FIRST, PH_KEY_START, PH_KEY, PH_COLON,
		PH_VALUE, PH_STR, PH_NUM, PH_AFTER, PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_FOUND = 2'd0, ST_MISSING = 2'd1, ST_ERROR = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		VT_NONE = 2'd0, VT_NUMBER = 2'd1, VT_STRING = 2'd2
	} vtype_t;

	localparam logic [1:0] REG_KEY_BYTES = 2'd0;
	localparam logic [1:0] REG_KEY_LENGTH = 2'd1;

	// byte class produced by the front part
	typedef struct packed {
		logic [7:0] b;
		logic last;
		logic ws;
		logic digit;
		logic [OFFSET_BITS-1:0] off;
		logic [OFFSET_BITS-1:0] off_next;
		logic [MAX_KEY_BYTES-1:0] khit;
		logic [KIDX_BITS-1:0] klen;
	} cls_t;

	typedef struct packed {
		logic [1:0] status;
		logic [1:0] value_type;
		logic [OUT_BITS-1:0] value_start;
		logic [OUT_BITS-1:0] value_length;
		logic [OUT_BITS-1:0] error_offset;
	} res_t;
endpackage

// ----- hw/rtl/jfke_if.sv -----
// Valid/ready channel interfaces for the key extractor.
// Stands alone; uses nothing from jfke_pkg.
interface jfke_in_if;
	logic valid;
	logic ready;
	logic [7:0] text_byte;
	logic last_byte;
	modport source (output valid, text_byte, last_byte, input ready);
	modport sink (input valid, text_byte, last_byte, output ready);
endinterface

interface jfke_out_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [1:0] value_type;
	logic [15:0] value_start;
	logic [15:0] value_length;
	logic [15:0] error_offset;
	modport source (output valid, status, value_type, value_start, value_length,
		error_offset, input ready);
	modport sink (input valid, status, value_type, value_start, value_length,
		error_offset, output ready);
endinterface

// ----- hw/rtl/jfke_front.sv -----
// Front part: accepts bytes, tracks offset, classifies each byte against every key byte.
// Depends on jfke_pkg. Pushes classified bytes into the queue.
module jfke_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] text_byte,
	input  logic last_byte,
	input  logic [63:0] key_bytes,
	input  logic [3:0] key_length,
	output logic push,
	output jfke_pkg::cls_t push_data,
	input  logic q_full
);
	import jfke_pkg::*;

	logic [OFFSET_BITS-1:0] off_q;
	logic [3:0] klen;

	assign in_ready = !q_full;
	assign push = in_valid && in_ready;
	assign klen = (key_length > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : key_length;

	always_comb begin
		push_data.b = text_byte;
		push_data.last = last_byte;
		push_data.ws = text_byte <= CH_SPACE;
		push_data.digit = text_byte >= 8'h30 && text_byte <= 8'h39;
		push_data.off = off_q;
		push_data.off_next = (off_q == OFFSET_MAX) ? off_q : off_q + 1'b1;
		for (int i = 0; i < MAX_KEY_BYTES; i++)
			push_data.khit[i] = key_bytes[8*i +: 8] == text_byte;
		push_data.klen = klen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else begin
			if (push) off_q <= last_byte ? '0 : push_data.off_next;
		end
	end
endmodule

// ----- hw/rtl/jfke_back.sv -----
// Back part: queue of classified bytes and the parse state machine.
// Depends on jfke_pkg. Drives the result register.
module jfke_back (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  jfke_pkg::cls_t push_data,
	output logic q_full,
	output logic res_valid,
	input  logic res_ready,
	output jfke_pkg::res_t res
);
	import jfke_pkg::*;

	cls_t q_mem [QDEPTH];
	logic [QPTR_BITS:0] cnt_q;
	logic [QPTR_BITS-1:0] wp_q, rp_q;
	cls_t c;
	logic pop, go;

	phase_t ph_q, ph_d;
	logic match_q, match_d, esc_q, esc_d, done_q, done_d;
	logic [OFFSET_BITS-1:0] vs_q, vs_d;
	logic [OUT_BITS-1:0] vl_q, vl_d;
	logic [1:0] vt_q, vt_d;
	logic [KIDX_BITS-1:0] kidx_q;
	logic kidx_clr, kidx_inc, kidx_ok, kbyte_hit;
	logic emit;
	res_t er;

	assign c = q_mem[rp_q];
	assign q_full = cnt_q == (QPTR_BITS+1)'(QDEPTH);
	assign go = cnt_q != '0 && (!res_valid || res_ready);
	assign pop = go;
	assign kidx_ok = kidx_q < c.klen;
	assign kbyte_hit = c.khit[kidx_q[2:0]];

	always_ff @(posedge clk) begin
		if (push) q_mem[wp_q] <= push_data;
	end

	function automatic res_t mk(status_t s, logic [1:0] t, logic [OFFSET_BITS-1:0] st,
			logic [OUT_BITS-1:0] ln, logic [OFFSET_BITS-1:0] eo);
		res_t r;
		r.status = s;
		r.value_type = t;
		r.value_start = st[OUT_BITS-1:0];
		r.value_length = ln;
		r.error_offset = eo[OUT_BITS-1:0];
		return r;
	endfunction

	always_comb begin
		ph_d = ph_q; match_d = match_q; esc_d = esc_q; done_d = done_q;
		vs_d = vs_q; vl_d = vl_q; vt_d = vt_q;
		emit = 1'b0; er = mk(ST_MISSING, VT_NONE, '0, '0, '0);
		kidx_clr = 1'b0; kidx_inc = 1'b0;
		if (!done_q) begin
			unique case (ph_q)
				PH_OPEN: begin
					if (!c.ws) begin
						if (c.b == CH_LBRACE) ph_d = PH_FIRST;
						else begin emit = 1'b1; er = mk(ST_ERROR, VT_NONE, '0, '0, c.off); end
					end
				end
				PH_FIRST, PH_KEY_START: begin
					if (!c.ws) begin
						if (c.b == CH_RBRACE && ph_q == PH_FIRST) emit = 1'b1;
						else if (c.b == CH_QUOTE) begin
							ph_d = PH_KEY; kidx_clr = 1'b1; match_d = 1'b1; esc_d = 1'b0;
						end else begin emit = 1'b1; er = mk(ST_ERROR, VT_NONE, '0, '0, c.off); end
					end
				end
				PH_KEY: begin
					if (esc_q) esc_d = 1'b0;
					else if (c.b == CH_BSLASH) begin esc_d = 1'b1; match_d = 1'b0; end
					else if (c.b == CH_QUOTE) begin
						match_d = match_q && !kidx_ok; ph_d = PH_COLON;
					end else if (kidx_ok && kbyte_hit) kidx_inc = 1'b1;
					else match_d = 1'b0;
				end
				PH_COLON: begin
					if (!c.ws) begin
						if (c.b == CH_COLON) ph_d = PH_VALUE;
						else begin emit = 1'b1; er = mk(ST_ERROR, VT_NONE, '0, '0, c.off); end
					end
				end
				PH_VALUE: begin
					if (!c.ws) begin
						if (c.b == CH_QUOTE) begin
							vt_d = VT_STRING; vs_d = c.off_next; vl_d = '0; esc_d = 1'b0;
							ph_d = PH_STR;
						end else if (c.b == CH_MINUS || c.digit) begin
							vt_d = VT_NUMBER; vs_d = c.off; vl_d = OUT_BITS'(1); ph_d = PH_NUM;
						end else begin emit = 1'b1; er = mk(ST_ERROR, VT_NONE, '0, '0, c.off); end
					end
				end
				PH_STR: begin
					if (esc_q) esc_d = 1'b0;
					else if (c.b == CH_QUOTE) begin
						if (match_q) begin emit = 1'b1; er = mk(ST_FOUND, vt_q, vs_q, vl_q, '0); end
						else ph_d = PH_AFTER;
					end else begin
						if (vl_q != LEN_MAX) vl_d = vl_q + 1'b1;
						if (c.b == CH_BSLASH) esc_d = 1'b1;
					end
				end
				PH_NUM: begin
					if (c.digit) begin
						if (vl_q != LEN_MAX) vl_d = vl_q + 1'b1;
					end else if (match_q) begin
						emit = 1'b1; er = mk(ST_FOUND, vt_q, vs_q, vl_q, '0);
					end else if (c.ws) ph_d = PH_AFTER;
					else if (c.b == CH_COMMA) ph_d = PH_KEY_START;
					else emit = 1'b1;
				end
				PH_AFTER: begin
					if (!c.ws) begin
						if (c.b == CH_COMMA) ph_d = PH_KEY_START;
						else emit = 1'b1;
					end
				end
				default: ;
			endcase
			if (c.last && !emit) begin
				emit = 1'b1;
				priority case (ph_d)
					PH_STR, PH_NUM:
						if (match_d) er = mk(ST_FOUND, vt_d, vs_d, vl_d, '0);
					PH_AFTER: ;
					default: er = mk(ST_ERROR, VT_NONE, '0, '0, c.off_next);
				endcase
			end
			if (emit) begin ph_d = PH_DONE; done_d = 1'b1; end
		end
		if (c.last) begin
			ph_d = PH_OPEN; match_d = 1'b1; esc_d = 1'b0; done_d = 1'b0;
			vs_d = '0; vl_d = '0; vt_d = VT_NONE; kidx_clr = 1'b1; kidx_inc = 1'b0;
		end
		if (!go) begin kidx_clr = 1'b0; kidx_inc = 1'b0; end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; wp_q <= '0; rp_q <= '0;
			ph_q <= PH_OPEN; match_q <= 1'b1; esc_q <= 1'b0; done_q <= 1'b0;
			vs_q <= '0; vl_q <= '0; vt_q <= VT_NONE;
			kidx_q <= '0;
			res_valid <= 1'b0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
			if (res_ready) res_valid <= 1'b0;
			if (kidx_clr) kidx_q <= '0;
			else if (kidx_inc) kidx_q <= kidx_q + 1'b1;
			if (go) begin
				ph_q <= ph_d; match_q <= match_d; esc_q <= esc_d; done_q <= done_d;
				vs_q <= vs_d; vl_q <= vl_d; vt_q <= vt_d;
				if (emit) res_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) res <= er;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push) else $error("queue overflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_BITS+1)'(QDEPTH)) else $error("queue count out of range");
	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ph_q == PH_DONE) else $error("done without done phase");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res)) else $error("result lost");
endmodule

// ----- hw/rtl/json_flat_object_key_extractor.sv -----
// JSON flat-object key extractor: one byte per transfer on the input channel,
// at most one report per document on the output channel.
// Byte stream: in (text_byte, last_byte); results: out (status, value_type,
// value_start, value_length, error_offset). Key set through the APB port:
// key_bytes at 0x0 (64 bits), key_length at 0x8.
// Throughput: one byte per cycle while the queue has room; the parse update is one state step.
// The byte that causes a report is held in a queue entry, and the report is
// then registered in the result register.
// A 4-entry queue parts the byte classifier from the parse machine, and the
// result register holds a report until taken; while it waits the queue
// fills and then in.ready drops.
// Reset clears offset, phase and queue; key registers read as zero.
// The parser restarts after every byte marked last.
module json_flat_object_key_extractor (
	input  logic clk,
	input  logic arst_n,
	jfke_in_if.sink in,
	jfke_out_if.source out,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	import jfke_pkg::*;

	logic [63:0] key_bytes_q;
	logic [3:0] key_length_q;
	logic [1:0] ridx;
	logic wr;
	logic push, q_full, res_valid;
	cls_t push_data;
	res_t res;

	assign pready = 1'b1;
	assign ridx = paddr[3] ? REG_KEY_LENGTH : REG_KEY_BYTES;
	assign wr = psel && penable && pwrite && (paddr[2:0] == 3'd0);

	always_comb begin
		prdata = '0;
		if (paddr == 4'd0) prdata = key_bytes_q;
		else if (paddr == 4'd8) prdata = {60'd0, key_length_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bytes_q <= '0;
			key_length_q <= '0;
		end else if (wr) begin
			if (ridx == REG_KEY_BYTES) key_bytes_q <= pwdata;
			else key_length_q <= pwdata[3:0];
		end
	end

	jfke_front u_front (
		.clk, .arst_n,
		.in_valid(in.valid), .in_ready(in.ready),
		.text_byte(in.text_byte), .last_byte(in.last_byte),
		.key_bytes(key_bytes_q), .key_length(key_length_q),
		.push, .push_data, .q_full
	);

	jfke_back u_back (
		.clk, .arst_n, .push, .push_data, .q_full,
		.res_valid, .res_ready(out.ready), .res
	);

	assign out.valid = res_valid;
	assign out.status = res.status;
	assign out.value_type = res.value_type;
	assign out.value_start = res.value_start;
	assign out.value_length = res.value_length;
	assign out.error_offset = res.error_offset;
endmodule

// ----- tb/sv/tb_json_flat_object_key_extractor.sv -----
// Testbench for json_flat_object_key_extractor: streams JSON documents byte by byte,
// predicts each report and checks it against the out channel, with APB key setup.
// Depends on jfke_pkg, jfke_if.sv and the RTL top.
module tb_json_flat_object_key_extractor;
	import jfke_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_CYCLES = 4000;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [63:0] pwdata, prdata;

	jfke_in_if in_ch();
	jfke_out_if out_ch();

	json_flat_object_key_extractor u_dut (
		.clk(clk), .arst_n(arst_n), .in(in_ch.sink), .out(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// parser copy
	logic [63:0] key_val;
	logic [3:0] key_len;
	phase_t ph;
	logic [15:0] pos;
	logic [3:0] kidx;
	bit kmatch, esc, done;
	logic [15:0] vstart, vlen;
	logic [1:0] vtype;

	res_t report_q[$];
	int idle_pct, stall_pct;
	int errors;
	int quiet_cycles;
	int sent_bytes;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic res_t mk(logic [1:0] st, logic [1:0] ty, logic [15:0] s,
			logic [15:0] l, logic [15:0] e);
		res_t r;
		r.status = st; r.value_type = ty; r.value_start = s;
		r.value_length = l; r.error_offset = e;
		return r;
	endfunction

	function void doc_restart();
		ph = PH_OPEN; pos = 0; kidx = 0; kmatch = 1; esc = 0;
		vstart = 0; vlen = 0; vtype = VT_NONE; done = 0;
	endfunction

	function void begin_key();
		ph = PH_KEY; kidx = 0; kmatch = 1; esc = 0;
	endfunction

	function automatic bit parse_byte(logic [7:0] b, bit last, output res_t r);
		bit hit;
		bit ws;
		bit dig;
		logic [3:0] klen;
		logic [15:0] nxt;
		hit = 0;
		r = '0;
		ws = b <= 8'd32;
		dig = b >= "0" && b <= "9";
		klen = key_len > 4'd8 ? 4'd8 : key_len;
		if (!done) begin
			case (ph)
				PH_OPEN: if (!ws) begin
					if (b == CH_LBRACE) ph = PH_FIRST;
					else begin hit = 1; r = mk(ST_ERROR, VT_NONE, 0, 0, pos); end
				end
				PH_FIRST: if (!ws) begin
					if (b == CH_RBRACE) begin hit = 1; r = mk(ST_MISSING, VT_NONE, 0, 0, 0); end
					else if (b == CH_QUOTE) begin_key();
					else begin hit = 1; r = mk(ST_ERROR, VT_NONE, 0, 0, pos); end
				end
				PH_KEY_START: if (!ws) begin
					if (b == CH_QUOTE) begin_key();
					else begin hit = 1; r = mk(ST_ERROR, VT_NONE, 0, 0, pos); end
				end
				PH_KEY: begin
					if (esc) esc = 0;
					else if (b == CH_BSLASH) begin
						esc = 1; kmatch = 0;
					end else if (b == CH_QUOTE) begin
						kmatch = kmatch && kidx == klen;
						ph = PH_COLON;
					end else if (kidx < klen && key_val[8*kidx +: 8] == b) kidx++;
					else kmatch = 0;
				end
				PH_COLON: if (!ws) begin
					if (b == CH_COLON) ph = PH_VALUE;
					else begin hit = 1; r = mk(ST_ERROR, VT_NONE, 0, 0, pos); end
				end
				PH_VALUE: if (!ws) begin
					if (b == CH_QUOTE) begin
						vtype = VT_STRING;
						vstart = pos == OFFSET_MAX ? pos : pos + 16'd1;
						vlen = 0; esc = 0; ph = PH_STR;
					end else if (b == CH_MINUS || dig) begin
						vtype = VT_NUMBER; vstart = pos; vlen = 1; ph = PH_NUM;
					end else begin hit = 1; r = mk(ST_ERROR, VT_NONE, 0, 0, pos); end
				end
				PH_STR: begin
					if (esc) esc = 0;
					else if (b == CH_QUOTE) begin
						if (kmatch) begin hit = 1; r = mk(ST_FOUND, vtype, vstart, vlen, 0); end
						else ph = PH_AFTER;
					end else begin
						if (vlen != LEN_MAX) vlen++;
						if (b == CH_BSLASH) esc = 1;
					end
				end
				PH_NUM: begin
					if (dig) begin
						if (vlen != LEN_MAX) vlen++;
					end else if (kmatch) begin
						hit = 1; r = mk(ST_FOUND, vtype, vstart, vlen, 0);
					end else begin
						ph = PH_AFTER;
						if (!ws) begin
							if (b == CH_COMMA) ph = PH_KEY_START;
							else begin hit = 1; r = mk(ST_MISSING, VT_NONE, 0, 0, 0); end
						end
					end
				end
				PH_AFTER: if (!ws) begin
					if (b == CH_COMMA) ph = PH_KEY_START;
					else begin hit = 1; r = mk(ST_MISSING, VT_NONE, 0, 0, 0); end
				end
				default: ;
			endcase
		end
		if (hit) begin
			done = 1; ph = PH_DONE;
		end
		nxt = pos == OFFSET_MAX ? pos : pos + 16'd1;
		pos = nxt;
		if (last) begin
			if (!hit && !done) begin
				hit = 1;
				case (ph)
					PH_STR, PH_NUM: r = kmatch ? mk(ST_FOUND, vtype, vstart, vlen, 0)
						: mk(ST_MISSING, VT_NONE, 0, 0, 0);
					PH_AFTER: r = mk(ST_MISSING, VT_NONE, 0, 0, 0);
					default: r = mk(ST_ERROR, VT_NONE, 0, 0, nxt);
				endcase
			end
			doc_restart();
		end
		return hit;
	endfunction

	always @(posedge clk) begin
		res_t r, e;
		bit moved;
		if (arst_n) begin
			moved = 0;
			if (in_ch.valid && in_ch.ready) begin
				moved = 1;
				if (parse_byte(in_ch.text_byte, in_ch.last_byte, r)) report_q.push_back(r);
			end
			if (out_ch.valid && out_ch.ready) begin
				moved = 1;
				if (report_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected report exp none got status=%0d", $time,
						out_ch.status);
				end else begin
					e = report_q.pop_front();
					if (out_ch.status !== e.status) begin
						errors++;
						$display("%0t: status exp %0d got %0d", $time, e.status, out_ch.status);
					end
					if (out_ch.value_type !== e.value_type) begin
						errors++;
						$display("%0t: value_type exp %0d got %0d", $time, e.value_type,
							out_ch.value_type);
					end
					if (out_ch.value_start !== e.value_start) begin
						errors++;
						$display("%0t: value_start exp %0d got %0d", $time, e.value_start,
							out_ch.value_start);
					end
					if (out_ch.value_length !== e.value_length) begin
						errors++;
						$display("%0t: value_length exp %0d got %0d", $time, e.value_length,
							out_ch.value_length);
					end
					if (out_ch.error_offset !== e.error_offset) begin
						errors++;
						$display("%0t: error_offset exp %0d got %0d", $time, e.error_offset,
							out_ch.error_offset);
					end
				end
			end
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	always @(negedge clk) out_ch.ready <= $urandom_range(99) >= stall_pct;

	task automatic send_byte(logic [7:0] b, bit last);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 0;
			@(negedge clk);
		end
		in_ch.valid <= 1;
		in_ch.text_byte <= b;
		in_ch.last_byte <= last;
		do @(posedge clk); while (!in_ch.ready);
		sent_bytes++;
	endtask

	task automatic send_doc(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
	endtask

	// drain before touching the key registers
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 0;
		wait (report_q.size() == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [63:0] data);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= 4'(int'(idx) * 8); pwdata <= data;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic set_key(logic [63:0] kb, logic [3:0] kl);
		settle();
		apb_write(REG_KEY_BYTES, kb);
		apb_write(REG_KEY_LENGTH, 64'(kl));
		key_val = kb;
		key_len = kl;
	endtask

	function automatic logic [63:0] pack_key(string s);
		logic [63:0] k;
		k = '0;
		for (int i = 0; i < s.len() && i < 8; i++) k[8*i +: 8] = s[i];
		return k;
	endfunction

	function automatic string rand_name(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'("a" + $urandom_range(2)))};
		return s;
	endfunction

	function automatic string rand_ws();
		case ($urandom_range(7))
			0: return " ";
			1: return "\n";
			2: return string'(8'($urandom_range(1, 32)));
			default: return "";
		endcase
	endfunction

	// well-formed object, then optionally corrupted, cut short or extended with random bytes
	task automatic send_random_doc(string key);
		string s, v;
		logic [7:0] bytes[$];
		int n, cut;
		s = {rand_ws(), "{"};
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++) begin
			if (i) s = {s, rand_ws(), ","};
			s = {s, rand_ws(), "\""};
			if ($urandom_range(3) == 0) s = {s, key};
			else s = {s, rand_name($urandom_range(0, 9))};
			if ($urandom_range(15) == 0) s = {s, "\\\""};
			s = {s, "\"", rand_ws(), ":", rand_ws()};
			if ($urandom_range(1)) begin
				v = $urandom_range(1) ? "-" : "";
				for (int j = $urandom_range(0, 6); j >= 0; j--)
					v = {v, string'(8'("0" + $urandom_range(9)))};
			end else begin
				v = "\"";
				for (int j = $urandom_range(0, 6); j > 0; j--)
					v = {v, $urandom_range(4) == 0 ? "\\n" : rand_name(1)};
				v = {v, "\""};
			end
			s = {s, v, rand_ws()};
		end
		s = {s, "}", rand_ws()};
		for (int i = 0; i < s.len(); i++) bytes.push_back(s[i]);
		case ($urandom_range(9))
			0: bytes[$urandom_range(bytes.size() - 1)] = 8'($urandom);
			1: begin
				cut = $urandom_range(1, bytes.size());
				while (bytes.size() > cut) void'(bytes.pop_back());
			end
			2: for (int i = $urandom_range(1, 6); i > 0; i--) bytes.push_back(8'($urandom));
			default: ;
		endcase
		foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	task automatic test_directed();
		idle_pct = 0; stall_pct = 0;
		set_key(pack_key("id"), 4'd2);
		send_doc("{\"id\":123,");
		send_doc("{\"id\":\"a\\\"b\"}");
		send_doc("{\"x\":1,\"id\":-5 }");
		send_doc("\000 {\"id\":42");
		send_doc("{\"i\\d\":1}");
		send_doc("{\"id\":1;}x");
		send_doc("{}");
		send_doc("x");
		send_doc("{\"id\"");
		send_doc("{\"a\":\"q\"");
		send_doc("{\"a\" 7");
		send_doc("{\"a\":}");
		send_doc("{,");
		send_doc("{\"a\":1 \"");
		send_byte(8'hff, 0);
		send_byte(8'h00, 1);
	endtask

	task automatic test_key_extremes();
		set_key(64'hffff_ffff_ffff_ffff, 4'd8);
		send_doc({"{\"", string'(8'hff), "\":1}"});
		set_key(pack_key("abcabcab"), 4'd15);
		send_doc("{\"abcabcab\":77}");
		set_key(64'h0, 4'd0);
		send_doc("{\"\":\"e\"}");
	endtask

	task automatic test_random(int idle, int stall, int nbytes);
		string key;
		int start;
		idle_pct = idle; stall_pct = stall;
		key = rand_name($urandom_range(0, 8));
		set_key(pack_key(key), $urandom_range(9) == 0 ? 4'd15 : 4'(key.len()));
		start = sent_bytes;
		while (sent_bytes - start < nbytes) begin
			send_random_doc(key);
			if ($urandom_range(15) == 0) send_byte(8'($urandom), $urandom_range(1));
		end
	endtask

	initial begin
		errors = 0; quiet_cycles = 0; sent_bytes = 0;
		idle_pct = 0; stall_pct = 0;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_ch.valid = 0; in_ch.text_byte = 0; in_ch.last_byte = 0;
		out_ch.ready = 0;
		key_val = 0; key_len = 0;
		doc_restart();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		test_key_extremes();
		test_random(0, 0, 210);
		test_random(70, 0, 210);
		test_random(0, 70, 210);
		test_random(20, 20, 210);
		settle();
		repeat (10) @(posedge clk);
		if (errors == 0 && report_q.size() == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
